// File: design/gcr_pkg.sv
// shared types, constants and glyph rom for the 3x5 cell renderer
package gcr_pkg;

   localparam int unsigned CELL_W = 4;
   localparam int unsigned CELL_H = 5;
   localparam int unsigned GLYPH_COLS = 3;
   localparam int unsigned GLYPH_BITS = GLYPH_COLS * CELL_H;

   localparam logic [7:0] VIEW_WIDTH_RST  = 8'd128;
   localparam logic [7:0] VIEW_HEIGHT_RST = 8'd97;
   localparam logic [7:0] ORIGIN_COL_RST  = 8'd0;
   localparam logic [7:0] ORIGIN_ROW_RST  = 8'd32;

   typedef enum logic [1:0] {
      CSR_VIEW_WIDTH  = 2'd0,
      CSR_VIEW_HEIGHT = 2'd1,
      CSR_ORIGIN_COL  = 2'd2,
      CSR_ORIGIN_ROW  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] view_width;
      logic [7:0] view_height;
      logic [7:0] origin_col;
      logic [7:0] origin_row;
   } cfg_type;

   typedef struct packed {
      logic [8:0]  ram_col;
      logic [8:0]  ram_row;
      logic [15:0] pixel_color;
      logic        cell_burst;
      logic        last_pixel;
   } pixel_type;

   // glyph columns packed as {col2, col1, col0}, bit r of a column is row r
   function automatic logic [GLYPH_BITS-1:0] glyph_lookup(input logic [7:0] code);
      logic [GLYPH_BITS-1:0] g;
      unique case (code)
         8'h3A:   g = {5'h00, 5'h0A, 5'h00};
         8'h2F:   g = {5'h04, 5'h08, 5'h10};
         8'h3E:   g = {5'h11, 5'h0A, 5'h04};
         8'h30:   g = {5'h1F, 5'h11, 5'h1F};
         8'h31:   g = {5'h00, 5'h1F, 5'h00};
         8'h32:   g = {5'h17, 5'h15, 5'h1D};
         8'h33:   g = {5'h1F, 5'h15, 5'h15};
         8'h34:   g = {5'h1F, 5'h04, 5'h07};
         8'h35:   g = {5'h1D, 5'h15, 5'h17};
         8'h36:   g = {5'h1D, 5'h15, 5'h1F};
         8'h37:   g = {5'h1F, 5'h01, 5'h01};
         8'h38:   g = {5'h1F, 5'h15, 5'h1F};
         8'h39:   g = {5'h1F, 5'h15, 5'h17};
         8'h41:   g = {5'h1F, 5'h05, 5'h1F};
         8'h42:   g = {5'h0A, 5'h15, 5'h1F};
         8'h43:   g = {5'h11, 5'h11, 5'h1F};
         8'h44:   g = {5'h0E, 5'h11, 5'h1F};
         8'h45:   g = {5'h11, 5'h15, 5'h1F};
         8'h46:   g = {5'h01, 5'h05, 5'h1F};
         8'h47:   g = {5'h1D, 5'h11, 5'h1F};
         8'h48:   g = {5'h1F, 5'h04, 5'h1F};
         8'h49:   g = {5'h11, 5'h1F, 5'h11};
         8'h4B:   g = {5'h1B, 5'h04, 5'h1F};
         8'h4C:   g = {5'h10, 5'h10, 5'h1F};
         8'h4D:   g = {5'h1F, 5'h02, 5'h1F};
         8'h4E:   g = {5'h1E, 5'h01, 5'h1F};
         8'h4F:   g = {5'h1F, 5'h11, 5'h1F};
         8'h50:   g = {5'h07, 5'h05, 5'h1F};
         8'h52:   g = {5'h17, 5'h0D, 5'h1F};
         8'h53:   g = {5'h1D, 5'h15, 5'h17};
         8'h54:   g = {5'h01, 5'h1F, 5'h01};
         8'h55:   g = {5'h1F, 5'h10, 5'h1F};
         8'h56:   g = {5'h0F, 5'h10, 5'h0F};
         8'h57:   g = {5'h1F, 5'h08, 5'h1F};
         8'h58:   g = {5'h1B, 5'h04, 5'h1B};
         8'h59:   g = {5'h03, 5'h1C, 5'h03};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// File: design/gcr_req_if.sv
// character request channel
interface gcr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  start_x;
   logic [7:0]  start_y;
   logic [7:0]  char_code;
   logic [15:0] fore_color;
   logic [15:0] back_color;

   modport source (output valid, start_x, start_y, char_code, fore_color, back_color,
                   input ready);
   modport sink (input valid, start_x, start_y, char_code, fore_color, back_color,
                 output ready);
endinterface

// File: design/gcr_rsp_if.sv
// pixel result channel
interface gcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  ram_col;
   logic [8:0]  ram_row;
   logic [15:0] pixel_color;
   logic        cell_burst;
   logic        last_pixel;

   modport source (output valid, ram_col, ram_row, pixel_color, cell_burst, last_pixel,
                   input ready);
   modport sink (input valid, ram_col, ram_row, pixel_color, cell_burst, last_pixel,
                 output ready);
endinterface

// File: design/gcr_csr.sv
// configuration registers for view size and ram origin
module gcr_csr
   import gcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VIEW_WIDTH:  cfg_in.view_width  = csr_wdata;
            CSR_VIEW_HEIGHT: cfg_in.view_height = csr_wdata;
            CSR_ORIGIN_COL:  cfg_in.origin_col  = csr_wdata;
            CSR_ORIGIN_ROW:  cfg_in.origin_row  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_width  <= VIEW_WIDTH_RST;
         cfg_ff.view_height <= VIEW_HEIGHT_RST;
         cfg_ff.origin_col  <= ORIGIN_COL_RST;
         cfg_ff.origin_row  <= ORIGIN_ROW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/gcr_cell_walker.sv
// input register with clip setup and row-major walk over the visible cell pixels
module gcr_cell_walker
   import gcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   gcr_req_if.sink    req,
   input  logic       pix_ready,
   output logic       pix_valid,
   output pixel_type  pix
);

   logic                  busy_ff, busy_in;
   logic [1:0]            col_ff, col_in;
   logic [2:0]            row_ff, row_in;
   logic [1:0]            last_col_ff, last_col_in;
   logic [2:0]            last_row_ff, last_row_in;
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;
   logic                  burst_ff, burst_in;
   logic [8:0]            base_col_ff, base_col_in;
   logic [8:0]            base_row_ff, base_row_in;
   logic [15:0]           fore_ff, fore_in;
   logic [15:0]           back_ff, back_in;

   logic [8:0] span_x;
   logic [8:0] span_y;
   logic       fit_x;
   logic       fit_y;
   logic       on_screen;
   logic       accept;
   logic       advance;
   logic       is_last;
   logic [4:0] col_bits;
   logic       bit_set;

   // room left to the right and below the start pixel
   assign span_x    = {1'b0, cfg.view_width} - {1'b0, req.start_x};
   assign span_y    = {1'b0, cfg.view_height} - {1'b0, req.start_y};
   assign fit_x     = span_x >= 9'(CELL_W);
   assign fit_y     = span_y >= 9'(CELL_H);
   assign on_screen = (req.start_x < cfg.view_width) && (req.start_y < cfg.view_height);

   assign is_last   = (col_ff == last_col_ff) && (row_ff == last_row_ff);
   assign advance   = busy_ff && pix_ready;
   assign req.ready = !busy_ff || (pix_ready && is_last);
   assign accept    = req.valid && req.ready;

   always_comb begin
      busy_in     = busy_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      glyph_in    = glyph_ff;
      burst_in    = burst_ff;
      base_col_in = base_col_ff;
      base_row_in = base_row_ff;
      fore_in     = fore_ff;
      back_in     = back_ff;
      if (accept) begin
         busy_in     = on_screen;
         col_in      = '0;
         row_in      = '0;
         last_col_in = fit_x ? 2'(CELL_W - 1) : span_x[1:0] - 2'd1;
         last_row_in = fit_y ? 3'(CELL_H - 1) : span_y[2:0] - 3'd1;
         glyph_in    = glyph_lookup(req.char_code);
         burst_in    = fit_x && fit_y;
         base_col_in = {1'b0, cfg.origin_col} + {1'b0, req.start_x};
         base_row_in = {1'b0, cfg.origin_row} + {1'b0, req.start_y};
         fore_in     = req.fore_color;
         back_in     = req.back_color;
      end else if (advance) begin
         if (is_last) begin
            busy_in = 1'b0;
         end
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
   end

   // spacer column has no glyph bits
   always_comb begin
      case (col_ff)
         2'd0:    col_bits = glyph_ff[4:0];
         2'd1:    col_bits = glyph_ff[9:5];
         2'd2:    col_bits = glyph_ff[14:10];
         default: col_bits = '0;
      endcase
   end

   assign bit_set = (row_ff < 3'(CELL_H)) ? col_bits[row_ff] : 1'b0;

   assign pix_valid       = busy_ff;
   assign pix.ram_col     = base_col_ff + {7'd0, col_ff};
   assign pix.ram_row     = base_row_ff + {6'd0, row_ff};
   assign pix.pixel_color = bit_set ? fore_ff : back_ff;
   assign pix.cell_burst  = burst_ff;
   assign pix.last_pixel  = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      last_col_ff <= last_col_in;
      last_row_ff <= last_row_in;
      glyph_ff    <= glyph_in;
      burst_ff    <= burst_in;
      base_col_ff <= base_col_in;
      base_row_ff <= base_row_in;
      fore_ff     <= fore_in;
      back_ff     <= back_in;
   end

endmodule

// File: design/gcr_pixel_out.sv
// output register for pixel beats
module gcr_pixel_out
   import gcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pix_valid,
   input  pixel_type  pix,
   output logic       pix_ready,
   gcr_rsp_if.source  rsp
);

   logic      valid_ff, valid_in;
   pixel_type data_ff, data_in;

   assign pix_ready = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pix_ready) begin
         valid_in = pix_valid;
         data_in  = pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.ram_col     = data_ff.ram_col;
   assign rsp.ram_row     = data_ff.ram_row;
   assign rsp.pixel_color = data_ff.pixel_color;
   assign rsp.cell_burst  = data_ff.cell_burst;
   assign rsp.last_pixel  = data_ff.last_pixel;

endmodule

// File: design/glyph_3x5_cell_renderer_top.sv
// top level of the 3x5 glyph cell renderer
// latency: the first pixel beat passes the walker registers, then the output register
// throughput: one pixel beat per cycle unless the receiver stalls, set by the single pixel
//   walker and output register; a character gives one beat per visible pixel (up to 20)
// an off-screen character is accepted and gives no beats
// reset: synchronous, active high; clears the walker and output valid, loads view defaults
module glyph_3x5_cell_renderer_top
   import gcr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   gcr_req_if.sink   req,
   gcr_rsp_if.source rsp,
   input  logic      csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type   cfg;
   pixel_type pix;
   logic      pix_valid;
   logic      pix_ready;

   gcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcr_cell_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .pix_ready (pix_ready),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   gcr_pixel_out u_out (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready),
      .rsp       (rsp)
   );

endmodule

// File: tb/gcr_checker.sv
// checker for the 3x5 cell renderer: predicts pixel beats and compares them
`timescale 1ns / 100ps

module gcr_checker
   import gcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gcr_req_if         req,
   gcr_rsp_if         rsp,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         pending
);

   typedef logic [0:2][4:0] glyph_cols_type;

   cfg_type   view;
   pixel_type expected_pixels[$];

   // column 0 first, bit r of a column is row r
   function automatic glyph_cols_type font_columns(input logic [7:0] code);
      glyph_cols_type c;
      case (code)
         ":":     c = {5'h00, 5'h0A, 5'h00};
         "/":     c = {5'h10, 5'h08, 5'h04};
         ">":     c = {5'h04, 5'h0A, 5'h11};
         "0":     c = {5'h1F, 5'h11, 5'h1F};
         "1":     c = {5'h00, 5'h1F, 5'h00};
         "2":     c = {5'h1D, 5'h15, 5'h17};
         "3":     c = {5'h15, 5'h15, 5'h1F};
         "4":     c = {5'h07, 5'h04, 5'h1F};
         "5":     c = {5'h17, 5'h15, 5'h1D};
         "6":     c = {5'h1F, 5'h15, 5'h1D};
         "7":     c = {5'h01, 5'h01, 5'h1F};
         "8":     c = {5'h1F, 5'h15, 5'h1F};
         "9":     c = {5'h17, 5'h15, 5'h1F};
         "A":     c = {5'h1F, 5'h05, 5'h1F};
         "B":     c = {5'h1F, 5'h15, 5'h0A};
         "C":     c = {5'h1F, 5'h11, 5'h11};
         "D":     c = {5'h1F, 5'h11, 5'h0E};
         "E":     c = {5'h1F, 5'h15, 5'h11};
         "F":     c = {5'h1F, 5'h05, 5'h01};
         "G":     c = {5'h1F, 5'h11, 5'h1D};
         "H":     c = {5'h1F, 5'h04, 5'h1F};
         "I":     c = {5'h11, 5'h1F, 5'h11};
         "K":     c = {5'h1F, 5'h04, 5'h1B};
         "L":     c = {5'h1F, 5'h10, 5'h10};
         "M":     c = {5'h1F, 5'h02, 5'h1F};
         "N":     c = {5'h1F, 5'h01, 5'h1E};
         "O":     c = {5'h1F, 5'h11, 5'h1F};
         "P":     c = {5'h1F, 5'h05, 5'h07};
         "R":     c = {5'h1F, 5'h0D, 5'h17};
         "S":     c = {5'h17, 5'h15, 5'h1D};
         "T":     c = {5'h01, 5'h1F, 5'h01};
         "U":     c = {5'h1F, 5'h10, 5'h1F};
         "V":     c = {5'h0F, 5'h10, 5'h0F};
         "W":     c = {5'h1F, 5'h08, 5'h1F};
         "X":     c = {5'h1B, 5'h04, 5'h1B};
         "Y":     c = {5'h03, 5'h1C, 5'h03};
         default: c = '0;
      endcase
      return c;
   endfunction

   task automatic render_cell(input logic [7:0] sx, input logic [7:0] sy,
                              input logic [7:0] code, input logic [15:0] fg,
                              input logic [15:0] bg);
      glyph_cols_type cols;
      pixel_type   px;
      pixel_type   prev;
      bit          have_prev;
      bit          fits;
      int          x;
      int          y;
      if (sx >= view.view_width || sy >= view.view_height) return;
      cols = font_columns(code);
      fits = (int'(sx) + CELL_W <= int'(view.view_width)) &&
             (int'(sy) + CELL_H <= int'(view.view_height));
      have_prev = 1'b0;
      prev = '0;
      for (int r = 0; r < CELL_H; r++) begin
         for (int c = 0; c < CELL_W; c++) begin
            x = int'(sx) + c;
            y = int'(sy) + r;
            if (fits || (x < int'(view.view_width) && y < int'(view.view_height))) begin
               px.ram_col = 9'(int'(view.origin_col) + x);
               px.ram_row = 9'(int'(view.origin_row) + y);
               px.pixel_color = (c < 3 && cols[c][r]) ? fg : bg;
               px.cell_burst = fits;
               px.last_pixel = 1'b0;
               if (have_prev) expected_pixels.push_back(prev);
               prev = px;
               have_prev = 1'b1;
            end
         end
      end
      prev.last_pixel = 1'b1;
      expected_pixels.push_back(prev);
   endtask

   task automatic report_mismatch(input string what, input pixel_type exp_px,
                                  input pixel_type got_px);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected col=%0d row=%0d color=%h burst=%b last=%b",
                  $realtime, what, exp_px.ram_col, exp_px.ram_row, exp_px.pixel_color,
                  exp_px.cell_burst, exp_px.last_pixel);
         $display("%0t: %s:      got col=%0d row=%0d color=%h burst=%b last=%b",
                  $realtime, what, got_px.ram_col, got_px.ram_row, got_px.pixel_color,
                  got_px.cell_burst, got_px.last_pixel);
      end
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
      view = {VIEW_WIDTH_RST, VIEW_HEIGHT_RST, ORIGIN_COL_RST, ORIGIN_ROW_RST};
   end

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         view = {VIEW_WIDTH_RST, VIEW_HEIGHT_RST, ORIGIN_COL_RST, ORIGIN_ROW_RST};
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_VIEW_WIDTH:  view.view_width  = csr_wdata;
               CSR_VIEW_HEIGHT: view.view_height = csr_wdata;
               CSR_ORIGIN_COL:  view.origin_col  = csr_wdata;
               CSR_ORIGIN_ROW:  view.origin_row  = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid === 1'b1 && req.ready === 1'b1)
            render_cell(req.start_x, req.start_y, req.char_code, req.fore_color,
                        req.back_color);
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            got.ram_col = rsp.ram_col;
            got.ram_row = rsp.ram_row;
            got.pixel_color = rsp.pixel_color;
            got.cell_burst = rsp.cell_burst;
            got.last_pixel = rsp.last_pixel;
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected pixel beat", '0, got);
            end else begin
               want = expected_pixels.pop_front();
               if (got.ram_col !== want.ram_col || got.ram_row !== want.ram_row ||
                   got.pixel_color !== want.pixel_color ||
                   got.cell_burst !== want.cell_burst ||
                   got.last_pixel !== want.last_pixel)
                  report_mismatch("pixel mismatch", want, got);
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// File: tb/tb.sv
// testbench top for the 3x5 cell renderer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;
   import gcr_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   int         mismatches;
   int         pending;
   bit         req_quiet;
   bit         rsp_quiet;
   logic [7:0] cur_w;
   logic [7:0] cur_h;
   string      glyph_set = " :/>0123456789ABCDEFGHIKLMNOPRSTUVWXY";

   gcr_req_if req_ch ();
   gcr_rsp_if rsp_ch ();

   glyph_3x5_cell_renderer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gcr_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [7:0] pick_coord(input logic [7:0] lim);
      int mode;
      int v;
      mode = $urandom_range(0, 9);
      if (mode <= 5 && lim != 0) begin
         v = $urandom_range(0, int'(lim) - 1);
      end else if (mode <= 7) begin
         v = int'(lim) - 5 + $urandom_range(0, 6);
         if (v < 0) v = 0;
         if (v > 255) v = 255;
      end else begin
         v = $urandom_range(0, 255);
      end
      return 8'(v);
   endfunction

   task automatic send_char(input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] code, input logic [15:0] fg,
                            input logic [15:0] bg);
      int gap;
      if ($urandom_range(0, 15) == 0) req_quiet = ($urandom_range(0, 2) == 0);
      gap = req_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.start_x    <= x;
      req_ch.start_y    <= y;
      req_ch.char_code  <= code;
      req_ch.fore_color <= fg;
      req_ch.back_color <= bg;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic set_view(input logic [7:0] w, input logic [7:0] h,
                           input logic [7:0] oc, input logic [7:0] orow);
      drain();
      write_reg(CSR_VIEW_WIDTH, w);
      write_reg(CSR_VIEW_HEIGHT, h);
      write_reg(CSR_ORIGIN_COL, oc);
      write_reg(CSR_ORIGIN_ROW, orow);
      csr_wr_en <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   task automatic random_chars(input int n);
      logic [7:0] code;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 7)
            code = glyph_set[$urandom_range(0, glyph_set.len() - 1)];
         else
            code = 8'($urandom_range(0, 255));
         send_char(pick_coord(cur_w), pick_coord(cur_h), code, 16'($urandom),
                   16'($urandom));
      end
   endtask

   // receiver: random stalls, quiet stretches and one long hold-off
   initial begin
      int gap;
      int pixel_beats;
      bit held;
      pixel_beats = 0;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && pixel_beats >= 120) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         if ($urandom_range(0, 15) == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
         gap = rsp_quiet ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         pixel_beats++;
         @(negedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.char_code = '0;
      req_ch.fore_color = '0;
      req_ch.back_color = '0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      cur_w = VIEW_WIDTH_RST;
      cur_h = VIEW_HEIGHT_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset view: 128 x 97, origin (0, 32)
      send_char(8'd0, 8'd0, "0", 16'hFFFF, 16'h0000);
      send_char(8'd0, 8'd0, "A", 16'h0000, 16'hFFFF);
      send_char(8'd124, 8'd92, "8", 16'hAAAA, 16'h5555);
      send_char(8'd125, 8'd92, "W", 16'h5555, 16'hAAAA);
      send_char(8'd124, 8'd93, "M", 16'hF800, 16'h07E0);
      send_char(8'd127, 8'd96, "X", 16'h001F, 16'hFFE0);
      send_char(8'd128, 8'd10, "1", 16'h1234, 16'h4321);
      send_char(8'd10, 8'd97, "2", 16'h1234, 16'h4321);
      send_char(8'd255, 8'd255, "3", 16'hFFFF, 16'hFFFF);
      send_char(8'd40, 8'd40, "a", 16'hFFFF, 16'h0000);
      send_char(8'd41, 8'd40, 8'h80, 16'hFFFF, 16'h0000);
      send_char(8'd42, 8'd40, 8'hFF, 16'hFFFF, 16'h0000);
      send_char(8'd43, 8'd40, " ", 16'hFFFF, 16'h0000);
      send_char(8'd44, 8'd40, "/", 16'hC3C3, 16'h3C3C);
      send_char(8'd45, 8'd40, ">", 16'h3C3C, 16'hC3C3);
      send_char(8'd46, 8'd41, ":", 16'h0F0F, 16'hF0F0);
      random_chars(70);

      // one-cell view of 4 x 5 with the origin at (255, 255)
      set_view(8'd4, 8'd5, 8'd255, 8'd255);
      send_char(8'd0, 8'd0, "B", 16'hFFFF, 16'h0000);
      send_char(8'd1, 8'd0, "R", 16'h0000, 16'hFFFF);
      send_char(8'd0, 8'd1, "K", 16'h8001, 16'h7FFE);
      send_char(8'd3, 8'd4, "Y", 16'h1111, 16'h2222);
      send_char(8'd4, 8'd0, "Y", 16'h1111, 16'h2222);
      random_chars(30);

      set_view(8'd255, 8'd255, 8'd0, 8'd0);
      random_chars(60);

      // view narrower than a cell: everything clipped
      set_view(8'd2, 8'd3, 8'd100, 8'd7);
      send_char(8'd0, 8'd0, "H", 16'hFFFF, 16'h0000);
      send_char(8'd1, 8'd2, "H", 16'hFFFF, 16'h0000);
      send_char(8'd2, 8'd0, "H", 16'hFFFF, 16'h0000);
      random_chars(20);

      for (int p = 0; p < 3; p++) begin
         if (p == 1)
            set_view(8'($urandom_range(4, 255)), 8'($urandom_range(5, 255)),
                     8'($urandom), 8'($urandom));
         else
            set_view(8'($urandom_range(4, 40)), 8'($urandom_range(5, 40)),
                     8'($urandom), 8'($urandom));
         random_chars(55);
      end

      drain();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
